### rtl/bbw_pkg.sv
// Shared types and constants for the bark/bite watchdog.
package bbw_pkg;

  localparam int unsigned BUS_W = 32;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } bbw_op_t;

  typedef enum logic [1:0] {
    REG_PET    = 2'd0,
    REG_ENABLE = 2'd1,
    REG_BARK   = 2'd2,
    REG_BITE   = 2'd3
  } bbw_reg_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [1:0]       idx;
    logic [BUS_W-1:0] val;
  } bbw_item_t;

  typedef struct packed {
    logic [BUS_W-1:0] read_value;
    logic             bark;
    logic             bite;
  } bbw_result_t;

endpackage

### rtl/bark_bite_watchdog_unit.sv
// Top level: input register, watchdog core and result register.
// An accepted item is held in the input register; its result is registered in the result register.
// Throughput: one item per cycle while the output is not stalled; the input register and the result
// register each hold one item, so input is taken while a result waits.
// Reset (rst_n low, synchronous): count 0, disabled, both limits all ones,
// bite clear, both stages empty.
module bark_bite_watchdog_unit import bbw_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_operation,
  input  logic [1:0]       in_register_index,
  input  logic [BUS_W-1:0] in_write_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [BUS_W-1:0] out_read_value,
  output logic             out_bark_active,
  output logic             out_bite_active
);

  logic        s1_valid_r, s1_valid_nxt;
  bbw_item_t   s1_item_r;
  logic        out_valid_r, out_valid_nxt;
  bbw_result_t out_res_r;
  bbw_result_t core_res;
  logic        out_free, step, in_fire;

  assign out_free = !out_valid_r || out_ready;
  assign step     = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || step;
  assign in_fire  = in_valid && in_ready;

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !step);
  assign out_valid_nxt = step || (out_valid_r && !out_ready);

  bbw_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (s1_item_r),
    .result (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.op  <= in_operation;
      s1_item_r.idx <= in_register_index;
      s1_item_r.val <= in_write_value;
    end
    if (step) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_res_r.read_value;
  assign out_bark_active = out_res_r.bark;
  assign out_bite_active = out_res_r.bite;

`ifndef SYNTHESIS
  a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("pending item dropped while output stalled");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(out_res_r))
    else $error("stalled result overwritten");

  a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
    (step && (s1_item_r.op != OP_READ)) |=> (out_res_r.read_value == '0))
    else $error("nonzero read data on a non-read item");
`endif

endmodule

### rtl/bbw_core.sv
// Watchdog state registers and the combinational update for one item.
module bbw_core import bbw_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  bbw_item_t   item,
  output bbw_result_t result
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > BUS_W) ? COUNT_WIDTH : BUS_W;

  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic                   running_r, running_nxt;
  logic [BUS_W-1:0]       bark_lim_r, bark_lim_nxt;
  logic [BUS_W-1:0]       bite_lim_r, bite_lim_nxt;
  logic                   bite_r, bite_nxt;
  logic [BUS_W-1:0]       rd;
  logic [CMP_W-1:0]       count_ext, cnt_cur_ext;
  logic                   bark;

  assign cnt_cur_ext = CMP_W'(count_r);

  always_comb begin
    count_nxt    = count_r;
    running_nxt  = running_r;
    bark_lim_nxt = bark_lim_r;
    bite_lim_nxt = bite_lim_r;
    rd           = '0;
    unique case (item.op)
      OP_TICK: begin
        if (running_r && (count_r != {COUNT_WIDTH{1'b1}})) begin
          count_nxt = count_r + COUNT_WIDTH'(1);
        end
      end
      OP_WRITE: begin
        unique case (item.idx)
          REG_PET:    if (item.val[0]) count_nxt = '0;
          REG_ENABLE: running_nxt = item.val[0];
          REG_BARK:   bark_lim_nxt = item.val;
          REG_BITE:   bite_lim_nxt = item.val;
          default:    ;
        endcase
      end
      OP_READ: begin
        unique case (item.idx)
          REG_PET:    rd = cnt_cur_ext[BUS_W-1:0];
          REG_ENABLE: rd = BUS_W'(running_r);
          REG_BARK:   rd = bark_lim_r;
          REG_BITE:   rd = bite_lim_r;
          default:    rd = '0;
        endcase
      end
      default: ;
    endcase
    count_ext = CMP_W'(count_nxt);
    bite_nxt  = bite_r | (running_nxt && (count_ext >= CMP_W'(bite_lim_nxt)));
    bark      = running_nxt && (count_ext >= CMP_W'(bark_lim_nxt));
  end

  assign result.read_value = rd;
  assign result.bark       = bark;
  assign result.bite       = bite_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      running_r  <= 1'b0;
      bark_lim_r <= '1;
      bite_lim_r <= '1;
      bite_r     <= 1'b0;
    end else if (step) begin
      count_r    <= count_nxt;
      running_r  <= running_nxt;
      bark_lim_r <= bark_lim_nxt;
      bite_lim_r <= bite_lim_nxt;
      bite_r     <= bite_nxt;
    end
  end

`ifndef SYNTHESIS
  a_bite_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    bite_r |=> bite_r) else $error("bite cleared without reset");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> ($stable(count_r) && $stable(running_r) && $stable(bite_r)))
    else $error("state changed with no item");

  a_no_count_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |=> (count_r <= $past(count_r)))
    else $error("count advanced while disabled");
`endif

endmodule

### tb/bark_bite_watchdog_unit_tb.sv
// Self-checking testbench for the bark/bite watchdog: bus items in, checked results out.
module bark_bite_watchdog_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bbw_pkg::*;

  localparam int unsigned CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int LONG_HOLD = 60;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       in_operation = OP_TICK;
  logic [1:0]       in_register_index = REG_PET;
  logic [BUS_W-1:0] in_write_value = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [BUS_W-1:0] out_read_value;
  logic             out_bark_active;
  logic             out_bite_active;

  // watchdog state as predicted
  logic [CNT_W-1:0] wd_count = '0;
  logic             wd_running = 1'b0;
  logic [BUS_W-1:0] wd_bark_lim = '1;
  logic [BUS_W-1:0] wd_bite_lim = '1;
  logic             wd_bitten = 1'b0;

  bbw_result_t pending_results[$];
  int          mismatch_count = 0;

  // receiver control
  bit hold_req = 1'b0;
  bit rx_free = 1'b0;
  int hold_left = 0;
  int rx_phase = 0;

  bark_bite_watchdog_unit #(.COUNT_WIDTH(CNT_W)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_operation(in_operation),
    .in_register_index(in_register_index),
    .in_write_value(in_write_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_read_value(out_read_value),
    .out_bark_active(out_bark_active),
    .out_bite_active(out_bite_active)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bbw_result_t watchdog_step(logic [1:0] op, logic [1:0] idx,
                                                logic [BUS_W-1:0] val);
    bbw_result_t r;
    r = '0;
    case (op)
      OP_TICK: begin
        if (wd_running && wd_count != CNT_MAX) wd_count = wd_count + 1'b1;
      end
      OP_WRITE: begin
        case (idx)
          REG_PET:    if (val[0]) wd_count = '0;
          REG_ENABLE: wd_running = val[0];
          REG_BARK:   wd_bark_lim = val;
          default:    wd_bite_lim = val;
        endcase
      end
      OP_READ: begin
        case (idx)
          REG_PET:    r.read_value = BUS_W'(wd_count);
          REG_ENABLE: r.read_value = BUS_W'(wd_running);
          REG_BARK:   r.read_value = wd_bark_lim;
          default:    r.read_value = wd_bite_lim;
        endcase
      end
      default: ;
    endcase
    if (wd_running && 64'(wd_count) >= 64'(wd_bite_lim)) wd_bitten = 1'b1;
    r.bark = wd_running && 64'(wd_count) >= 64'(wd_bark_lim);
    r.bite = wd_bitten;
    return r;
  endfunction

  // result check, then prediction of the item taken at this edge
  always @(posedge clk) begin
    bbw_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no item pending");
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, out_read_value);
            mismatch_count++;
          end
          if (out_bark_active !== want.bark) begin
            $error("bark_active: expected %b, got %b", want.bark, out_bark_active);
            mismatch_count++;
          end
          if (out_bite_active !== want.bite) begin
            $error("bite_active: expected %b, got %b", want.bite, out_bite_active);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready)
        pending_results.push_back(watchdog_step(in_operation, in_register_index,
                                                in_write_value));
    end
  end

  always @(negedge clk) begin
    rx_phase++;
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else if (rx_free) begin
      out_ready = 1'b1;
    end else begin
      case ((rx_phase / 64) % 4)
        0:       out_ready = 1'b1;
        1:       out_ready = $urandom_range(0, 3) != 0;
        2:       out_ready = (rx_phase % 3) != 0;
        default: out_ready = $urandom_range(0, 9) < 4;
      endcase
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [1:0] idx,
                           input logic [BUS_W-1:0] val);
    @(negedge clk);
    in_valid = 1'b1;
    in_operation = op;
    in_register_index = idx;
    in_write_value = val;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_item(OP_READ, REG_PET, '0);
    send_item(OP_READ, REG_ENABLE, '1);
    send_item(OP_READ, REG_BARK, '0);
    send_item(OP_READ, REG_BITE, '0);
    send_item(OP_UNUSED, REG_BARK, '1);
    send_item(OP_TICK, REG_PET, '0);
    // pet with bit 0 clear does nothing
    send_item(OP_WRITE, REG_PET, 32'hFFFF_FFFE);
    send_item(OP_READ, REG_PET, '0);
  endtask

  task automatic test_bark_level();
    send_item(OP_WRITE, REG_BARK, 32'd3);
    send_item(OP_WRITE, REG_ENABLE, 32'd1);
    repeat (4) send_item(OP_TICK, REG_PET, '0);
    send_item(OP_READ, REG_PET, '0);
    send_item(OP_WRITE, REG_PET, 32'd2);
    send_item(OP_WRITE, REG_PET, 32'd1);
    repeat (3) send_item(OP_TICK, REG_PET, '1);
    // disable keeps the count
    send_item(OP_WRITE, REG_ENABLE, '0);
    send_item(OP_TICK, REG_PET, '0);
    send_item(OP_READ, REG_PET, '0);
    send_item(OP_WRITE, REG_BARK, '0);
    send_item(OP_WRITE, REG_ENABLE, 32'hFFFF_FFFF);
    send_item(OP_WRITE, REG_BARK, 32'hFFFF_FFFF);
    send_item(OP_READ, REG_BARK, '0);
    send_item(OP_READ, REG_ENABLE, '0);
  endtask

  task automatic test_bite_latch();
    send_item(OP_WRITE, REG_ENABLE, '0);
    send_item(OP_WRITE, REG_PET, 32'd1);
    send_item(OP_WRITE, REG_BITE, '0);
    // zero limit bites on the enabling item
    send_item(OP_WRITE, REG_ENABLE, 32'd1);
    repeat (3) send_item(OP_TICK, REG_PET, '0);
    send_item(OP_READ, REG_PET, '0);
    send_item(OP_WRITE, REG_BITE, '1);
    send_item(OP_READ, REG_BITE, '0);
  endtask

  // limit above the narrow count's range, then brought back within it
  task automatic test_wide_limit();
    rx_free = 1'b1;
    send_item(OP_WRITE, REG_BARK, 32'h0001_0000);
    send_item(OP_WRITE, REG_PET, 32'd1);
    send_item(OP_WRITE, REG_ENABLE, 32'd1);
    repeat (20) send_item(OP_TICK, REG_PET, '0);
    send_item(OP_READ, REG_PET, '0);
    send_item(OP_WRITE, REG_BARK, 32'd20);
    send_item(OP_WRITE, REG_PET, 32'd1);
    send_item(OP_READ, REG_PET, '0);
    wait_drained();
    rx_free = 1'b0;
  endtask

  task automatic random_item(input bit allow_bite);
    int               pick;
    logic [1:0]       op;
    logic [1:0]       idx;
    logic [BUS_W-1:0] val;
    pick = $urandom_range(0, 99);
    idx = 2'($urandom_range(0, 3));
    val = $urandom;
    if (pick < 50) op = OP_TICK;
    else if (pick < 75) op = OP_WRITE;
    else if (pick < 95) op = OP_READ;
    else op = OP_UNUSED;
    if (op == OP_WRITE) begin
      case (idx)
        REG_PET:    val[0] = 1'($urandom_range(0, 1));
        REG_ENABLE: val[0] = $urandom_range(0, 9) < 8;
        REG_BARK:   if ($urandom_range(0, 3) != 0) val = $urandom_range(0, 40);
        default: begin
          if (!allow_bite) val = val | 32'h0001_0000;
          else if ($urandom_range(0, 3) != 0) val = $urandom_range(0, 40);
        end
      endcase
    end
    send_item(op, idx, val);
  endtask

  task automatic test_random_traffic(input int n, input bit allow_bite);
    int burst;
    int gap;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) hold_req = 1'b1;
      if (i == (2 * n) / 3) wait_drained();
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        idle_cycles(gap);
      end
      burst--;
      random_item(allow_bite);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_state();
    test_bark_level();
    test_random_traffic(250, 1'b0);
    test_bite_latch();
    test_wide_limit();
    test_random_traffic(340, 1'b1);
    wait_drained();
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### filelist.f
rtl/bbw_pkg.sv
rtl/bbw_core.sv
rtl/bark_bite_watchdog_unit.sv
tb/bark_bite_watchdog_unit_tb.sv
